@@ rtl/llfd_pkg.sv @@
// Shared types and constants for the least-loaded FCFS dispatcher.
// Holds the sequencer state type, command and event codes, and the result beat.
// No dependencies.
package llfd_pkg;

    // field widths fixed by the interface
    localparam int EV_W   = 2;
    localparam int CORE_W = 3;
    localparam int ID_W   = 32;
    localparam int LEN_W  = 32;
    localparam int CFG_W  = 4;

    // reset value of the core count register
    localparam logic [CFG_W-1:0] NUM_CORES_RST = 4'd8;

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // event codes
    localparam logic [EV_W-1:0] EV_ACCEPT = 2'd0;
    localparam logic [EV_W-1:0] EV_REJECT = 2'd1;
    localparam logic [EV_W-1:0] EV_FINISH = 2'd2;
    localparam logic [EV_W-1:0] EV_IDLE   = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_ADEC,
        S_TMETA,
        S_TJOB,
        S_TMOD,
        S_TEND
    } t_state;

    // one result beat
    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [CORE_W-1:0] core;
        logic [ID_W-1:0]   job_id;
        logic              last;
    } t_result;

endpackage

@@ rtl/llfd_out_reg.sv @@
// Output register stage for result beats of the dispatcher.
// Holds one beat until the downstream side takes it.
// Depends on llfd_pkg.
module llfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  llfd_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output llfd_pkg::t_result o_res
);

    logic              r_valid;
    llfd_pkg::t_result r_res;

    // register is free when empty or its beat leaves this cycle
    assign o_free = !r_valid || !i_stall;

    // track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // capture the payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/least_loaded_fcfs_dispatcher.sv @@
// Add: taken only while idle, then one meta read per core in use, then the result beat.
// Tick: each of all MAX_CORES cores gets a meta read, and a busy core also a job read and a
//   write back; the final beat follows the sweep.
// One item at a time; a waiting result beat stalls the sequencer only when it must emit.
// Reset clears the sequencer, per-core queue valid bits (queues read as empty), next id to 1
//   and the core count to 8; the job store is not initialized.
module least_loaded_fcfs_dispatcher #(
    parameter int MAX_CORES   = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [llfd_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [llfd_pkg::LEN_W-1:0]  i_job_length,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [llfd_pkg::EV_W-1:0]   o_event_res,
    output logic [llfd_pkg::CORE_W-1:0] o_core,
    output logic [llfd_pkg::ID_W-1:0]   o_job_id,
    output logic                        o_last
);

    localparam int CIW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNW    = $clog2(MAX_CORES + 1);
    localparam int HW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int MW     = HW + CW;
    localparam int JDEPTH = MAX_CORES * QUEUE_DEPTH;
    localparam int AW     = $clog2(JDEPTH);
    localparam int JW     = llfd_pkg::ID_W + llfd_pkg::LEN_W;
    localparam logic [CNW-1:0] LAST_CORE = CNW'(MAX_CORES - 1);
    localparam logic [CW-1:0]  QD_CNT    = CW'(QUEUE_DEPTH);
    localparam logic [HW:0]    QD_SUM    = (HW + 1)'(QUEUE_DEPTH);

    // job store address of a core's slot
    function automatic logic [AW-1:0] job_addr(input logic [CIW-1:0] core,
                                               input logic [HW-1:0] slot);
        job_addr = AW'(core) * AW'(QUEUE_DEPTH) + AW'(slot);
    endfunction

    // memories: job entries {id, remaining} and per-core {head, count}
    logic [JW-1:0]        job_mem  [JDEPTH];
    logic [MW-1:0]        meta_mem [MAX_CORES];
    logic [MAX_CORES-1:0] r_meta_vld;

    llfd_pkg::t_state     r_state, n_state;
    logic [CNW-1:0]       r_idx, n_idx;
    logic                 r_rd_pend, n_rd_pend;
    logic [CIW-1:0]       r_rd_core, n_rd_core;
    logic [llfd_pkg::LEN_W-1:0] r_len, n_len;
    logic [CIW-1:0]       r_best_core, n_best_core;
    logic [HW-1:0]        r_best_head, n_best_head;
    logic [CW-1:0]        r_best_cnt, n_best_cnt;
    logic [llfd_pkg::ID_W-1:0] r_next_id, n_next_id;
    logic [llfd_pkg::CFG_W-1:0] r_num_cores;
    logic [HW-1:0]        r_cur_head, n_cur_head;
    logic [CW-1:0]        r_cur_cnt, n_cur_cnt;
    logic                 r_pend, n_pend;
    logic [CIW-1:0]       r_pend_core, n_pend_core;
    logic [llfd_pkg::ID_W-1:0] r_pend_id, n_pend_id;

    logic [MW-1:0]        r_meta_q;
    logic                 r_meta_qv;
    logic [JW-1:0]        r_job_q;

    logic                 w_meta_re, w_meta_we;
    logic [CIW-1:0]       w_meta_waddr;
    logic [MW-1:0]        w_meta_wdata;
    logic                 w_job_re, w_job_we;
    logic [AW-1:0]        w_job_raddr, w_job_waddr;
    logic [JW-1:0]        w_job_wdata;

    logic [CNW-1:0]       w_n_act;
    logic [HW-1:0]        w_meta_head;
    logic [CW-1:0]        w_meta_cnt;
    logic [HW:0]          w_slot_sum;
    logic [HW-1:0]        w_slot;
    logic [HW:0]          w_head_inc;
    logic [HW-1:0]        w_head_next;
    logic [llfd_pkg::LEN_W-1:0] w_rem;
    logic [llfd_pkg::ID_W-1:0]  w_jid;
    logic                 w_fin;
    logic                 w_in_acc;
    logic                 w_load;
    logic                 w_out_free;
    llfd_pkg::t_result    w_res;
    llfd_pkg::t_result    w_out_res;

    assign o_in_stall = (r_state != llfd_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // clamp the core count register to 1..MAX_CORES
    always_comb begin
        if (r_num_cores == '0) begin
            w_n_act = CNW'(1);
        end else if (int'(r_num_cores) > MAX_CORES) begin
            w_n_act = CNW'(MAX_CORES);
        end else begin
            w_n_act = CNW'(r_num_cores);
        end
    end

    // never-written queue metadata reads as empty
    assign w_meta_head = r_meta_qv ? r_meta_q[MW-1:CW] : '0;
    assign w_meta_cnt  = r_meta_qv ? r_meta_q[CW-1:0]  : '0;

    // tail slot of the chosen queue
    assign w_slot_sum = (HW + 1)'(r_best_head) + (HW + 1)'(r_best_cnt);
    assign w_slot     = (w_slot_sum >= QD_SUM) ? HW'(w_slot_sum - QD_SUM) : HW'(w_slot_sum);

    // head advance on pop
    assign w_head_inc  = (HW + 1)'(r_cur_head) + (HW + 1)'(1);
    assign w_head_next = (w_head_inc == QD_SUM) ? '0 : HW'(w_head_inc);

    // fields of the head job just read
    assign w_rem = r_job_q[llfd_pkg::LEN_W-1:0];
    assign w_jid = r_job_q[JW-1:llfd_pkg::LEN_W];
    assign w_fin = (w_rem <= llfd_pkg::LEN_W'(1));

    // sequencer: next state, memory accesses, result beats
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rd_pend   = r_rd_pend;
        n_rd_core   = r_rd_core;
        n_len       = r_len;
        n_best_core = r_best_core;
        n_best_head = r_best_head;
        n_best_cnt  = r_best_cnt;
        n_next_id   = r_next_id;
        n_cur_head  = r_cur_head;
        n_cur_cnt   = r_cur_cnt;
        n_pend      = r_pend;
        n_pend_core = r_pend_core;
        n_pend_id   = r_pend_id;
        w_meta_re    = 1'b0;
        w_meta_we    = 1'b0;
        w_meta_waddr = r_idx[CIW-1:0];
        w_meta_wdata = '0;
        w_job_re     = 1'b0;
        w_job_we     = 1'b0;
        w_job_raddr  = '0;
        w_job_waddr  = '0;
        w_job_wdata  = '0;
        w_load       = 1'b0;
        w_res        = '0;

        unique case (r_state)
            llfd_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_idx     = '0;
                    n_rd_pend = 1'b0;
                    if (i_cmd == llfd_pkg::CMD_ADD) begin
                        n_len   = i_job_length;
                        n_state = llfd_pkg::S_ASCAN;
                    end else begin
                        n_pend  = 1'b0;
                        n_state = llfd_pkg::S_TMETA;
                    end
                end
            end

            llfd_pkg::S_ASCAN: begin
                // compare the count read last cycle, lowest core wins a tie
                if (r_rd_pend && (r_rd_core == '0 || w_meta_cnt < r_best_cnt)) begin
                    n_best_core = r_rd_core;
                    n_best_head = w_meta_head;
                    n_best_cnt  = w_meta_cnt;
                end
                // issue the next read
                if (r_idx < w_n_act) begin
                    w_meta_re = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_core = r_idx[CIW-1:0];
                    n_idx     = r_idx + CNW'(1);
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_state = llfd_pkg::S_ADEC;
                    end
                end
            end

            llfd_pkg::S_ADEC: begin
                if (w_out_free) begin
                    w_load       = 1'b1;
                    w_res.core   = llfd_pkg::CORE_W'(r_best_core);
                    w_res.job_id = r_next_id;
                    w_res.last   = 1'b1;
                    if (r_best_cnt >= QD_CNT) begin
                        w_res.event_res = llfd_pkg::EV_REJECT;
                    end else begin
                        w_res.event_res = llfd_pkg::EV_ACCEPT;
                        w_job_we     = 1'b1;
                        w_job_waddr  = job_addr(r_best_core, w_slot);
                        w_job_wdata  = {r_next_id, r_len};
                        w_meta_we    = 1'b1;
                        w_meta_waddr = r_best_core;
                        w_meta_wdata = {r_best_head, r_best_cnt + CW'(1)};
                        n_next_id    = r_next_id + llfd_pkg::ID_W'(1);
                    end
                    n_state = llfd_pkg::S_IDLE;
                end
            end

            llfd_pkg::S_TMETA: begin
                w_meta_re = 1'b1;
                n_state   = llfd_pkg::S_TJOB;
            end

            llfd_pkg::S_TJOB: begin
                if (w_meta_cnt == '0) begin
                    // empty queue: skip to the next core
                    if (r_idx == LAST_CORE) begin
                        n_state = llfd_pkg::S_TEND;
                    end else begin
                        n_idx   = r_idx + CNW'(1);
                        n_state = llfd_pkg::S_TMETA;
                    end
                end else begin
                    w_job_re    = 1'b1;
                    w_job_raddr = job_addr(r_idx[CIW-1:0], w_meta_head);
                    n_cur_head  = w_meta_head;
                    n_cur_cnt   = w_meta_cnt;
                    n_state     = llfd_pkg::S_TMOD;
                end
            end

            llfd_pkg::S_TMOD: begin
                // hold while an earlier finish cannot be handed on
                if (!(w_fin && r_pend && !w_out_free)) begin
                    if (w_rem != '0) begin
                        w_job_we    = 1'b1;
                        w_job_waddr = job_addr(r_idx[CIW-1:0], r_cur_head);
                        w_job_wdata = {w_jid, w_rem - llfd_pkg::LEN_W'(1)};
                    end
                    if (w_fin) begin
                        w_meta_we    = 1'b1;
                        w_meta_wdata = {w_head_next, r_cur_cnt - CW'(1)};
                        if (r_pend) begin
                            w_load          = 1'b1;
                            w_res.event_res = llfd_pkg::EV_FINISH;
                            w_res.core      = llfd_pkg::CORE_W'(r_pend_core);
                            w_res.job_id    = r_pend_id;
                            w_res.last      = 1'b0;
                        end
                        n_pend      = 1'b1;
                        n_pend_core = r_idx[CIW-1:0];
                        n_pend_id   = w_jid;
                    end
                    if (r_idx == LAST_CORE) begin
                        n_state = llfd_pkg::S_TEND;
                    end else begin
                        n_idx   = r_idx + CNW'(1);
                        n_state = llfd_pkg::S_TMETA;
                    end
                end
            end

            llfd_pkg::S_TEND: begin
                // last finish carries the marker, or report an idle tick
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_res.last = 1'b1;
                    if (r_pend) begin
                        w_res.event_res = llfd_pkg::EV_FINISH;
                        w_res.core      = llfd_pkg::CORE_W'(r_pend_core);
                        w_res.job_id    = r_pend_id;
                    end else begin
                        w_res.event_res = llfd_pkg::EV_IDLE;
                    end
                    n_state = llfd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = llfd_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llfd_pkg::S_IDLE;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_pend      <= 1'b0;
            r_next_id   <= llfd_pkg::ID_W'(1);
            r_num_cores <= llfd_pkg::NUM_CORES_RST;
            r_meta_vld  <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_pend <= n_rd_pend;
            r_pend    <= n_pend;
            r_next_id <= n_next_id;
            if (i_cfg_we) begin
                r_num_cores <= i_cfg_data;
            end
            if (w_meta_we) begin
                r_meta_vld[w_meta_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_core   <= n_rd_core;
        r_len       <= n_len;
        r_best_core <= n_best_core;
        r_best_head <= n_best_head;
        r_best_cnt  <= n_best_cnt;
        r_cur_head  <= n_cur_head;
        r_cur_cnt   <= n_cur_cnt;
        r_pend_core <= n_pend_core;
        r_pend_id   <= n_pend_id;
    end

    // queue metadata memory; reads and writes never hit the same core in one cycle
    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            meta_mem[w_meta_waddr] <= w_meta_wdata;
        end
        if (w_meta_re) begin
            r_meta_q  <= meta_mem[r_idx[CIW-1:0]];
            r_meta_qv <= r_meta_vld[r_idx[CIW-1:0]];
        end
    end

    // job store memory
    always_ff @(posedge i_clk) begin
        if (w_job_we) begin
            job_mem[w_job_waddr] <= w_job_wdata;
        end
        if (w_job_re) begin
            r_job_q <= job_mem[w_job_raddr];
        end
    end

    // result beat register
    llfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (w_out_free),
        .o_res   (w_out_res)
    );

    assign o_event_res = w_out_res.event_res;
    assign o_core      = w_out_res.core;
    assign o_job_id    = w_out_res.job_id;
    assign o_last      = w_out_res.last;

    // a beat is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded while output register busy");

    // a head job is only modified for a non-empty queue
    a_tmod_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llfd_pkg::S_TMOD) |-> (r_cur_cnt != '0))
        else $error("tick modifying an empty queue");

    // queue occupancy never exceeds its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llfd_pkg::S_ADEC) |-> (r_best_cnt <= QD_CNT))
        else $error("queue count above depth");

    // an accepted beat starts the add scan or the tick sweep
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == llfd_pkg::S_ASCAN || r_state == llfd_pkg::S_TMETA))
        else $error("accepted beat did not start work");

endmodule

@@ sim/dispatch_monitor.sv @@
// Result checker for the least-loaded FCFS dispatcher: watches the register port and both
// channels, keeps its own copy of the per-core job queues and compares every result beat.
// Depends on llfd_pkg for the command and event codes and the result beat type.
module dispatch_monitor #(
    parameter int MAX_CORES   = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [llfd_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_cmd,
    input  logic [llfd_pkg::LEN_W-1:0]  i_job_length,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [llfd_pkg::EV_W-1:0]   i_event_res,
    input  logic [llfd_pkg::CORE_W-1:0] i_core,
    input  logic [llfd_pkg::ID_W-1:0]   i_job_id,
    input  logic                        i_last,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_beats,
    output int                          o_rejects,
    output int                          o_finishes,
    output int                          o_idle_ticks
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the dispatcher state
    logic [llfd_pkg::LEN_W-1:0] slot_len [MAX_CORES][QUEUE_DEPTH];
    logic [llfd_pkg::ID_W-1:0]  slot_id  [MAX_CORES][QUEUE_DEPTH];
    int                         q_head   [MAX_CORES];
    int                         q_count  [MAX_CORES];
    logic [llfd_pkg::ID_W-1:0]  next_id;
    logic [llfd_pkg::CFG_W-1:0] core_setting;

    // results still owed by the block, oldest first
    llfd_pkg::t_result owed_beats[$];

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_beats      = 0;
        o_rejects    = 0;
        o_finishes   = 0;
        o_idle_ticks = 0;
    end

    // append one expected beat behind the ones already owed
    function automatic void owe_beat(input llfd_pkg::t_result r);
        owed_beats = {owed_beats, r};
    endfunction

    function automatic void clear_queues();
        for (int c = 0; c < MAX_CORES; c++) begin
            q_head[c]  = 0;
            q_count[c] = 0;
        end
        next_id      = llfd_pkg::ID_W'(1);
        core_setting = llfd_pkg::NUM_CORES_RST;
        owed_beats.delete();
    endfunction

    // Place a new job on the shortest queue among the cores in use; lowest core wins a tie.
    function automatic void dispatch_add(input logic [llfd_pkg::LEN_W-1:0] len);
        int                n;
        int                best;
        int                slot;
        llfd_pkg::t_result r;
        if (core_setting == 0)
            n = 1;
        else if (core_setting > MAX_CORES)
            n = MAX_CORES;
        else
            n = int'(core_setting);
        best = 0;
        for (int c = 1; c < n; c++)
            if (q_count[c] < q_count[best])
                best = c;
        r.core   = llfd_pkg::CORE_W'(best);
        r.job_id = next_id;
        r.last   = 1'b1;
        if (q_count[best] >= QUEUE_DEPTH) begin
            // full queue: report the id it would have had, keep the id
            r.event_res = llfd_pkg::EV_REJECT;
        end else begin
            slot = (q_head[best] + q_count[best]) % QUEUE_DEPTH;
            slot_len[best][slot] = len;
            slot_id[best][slot]  = next_id;
            q_count[best]++;
            next_id++;
            r.event_res = llfd_pkg::EV_ACCEPT;
        end
        owe_beat(r);
    endfunction

    // Run one instruction on every busy core, retire heads that reach zero.
    function automatic void dispatch_tick();
        int                        fin_core [MAX_CORES];
        logic [llfd_pkg::ID_W-1:0] fin_id   [MAX_CORES];
        int                        k;
        int                        h;
        llfd_pkg::t_result         r;
        k = 0;
        for (int c = 0; c < MAX_CORES; c++) begin
            if (q_count[c] != 0) begin
                h = q_head[c];
                // a zero-length head finishes without running
                if (slot_len[c][h] != 0)
                    slot_len[c][h] = slot_len[c][h] - llfd_pkg::LEN_W'(1);
                if (slot_len[c][h] == 0) begin
                    fin_core[k] = c;
                    fin_id[k]   = slot_id[c][h];
                    k++;
                    q_head[c] = (h + 1) % QUEUE_DEPTH;
                    q_count[c]--;
                end
            end
        end
        if (k == 0) begin
            r.event_res = llfd_pkg::EV_IDLE;
            r.core      = '0;
            r.job_id    = '0;
            r.last      = 1'b1;
            owe_beat(r);
        end else begin
            for (int i = 0; i < k; i++) begin
                r.event_res = llfd_pkg::EV_FINISH;
                r.core      = llfd_pkg::CORE_W'(fin_core[i]);
                r.job_id    = fin_id[i];
                r.last      = (i == k - 1);
                owe_beat(r);
            end
        end
    endfunction

    function automatic void flag_error(input string what, input llfd_pkg::t_result want,
                                       input llfd_pkg::t_result seen);
        if (o_errors < 10)
            $display("%0t: %s: expected ev=%0d core=%0d id=%0d last=%0d,",
                     $realtime, what, want.event_res, want.core, want.job_id, want.last,
                     "  got ev=%0d core=%0d id=%0d last=%0d",
                     seen.event_res, seen.core, seen.job_id, seen.last);
        o_errors++;
    endfunction

    always @(posedge i_clk) begin
        llfd_pkg::t_result seen;
        llfd_pkg::t_result want;
        if (!i_rst_n) begin
            clear_queues();
        end else begin
            if (i_cfg_we)
                core_setting = i_cfg_data;

            // compare the output beat with the oldest owed result
            if (i_out_valid && !i_out_stall) begin
                seen.event_res = i_event_res;
                seen.core      = i_core;
                seen.job_id    = i_job_id;
                seen.last      = i_last;
                o_beats++;
                if (owed_beats.size() == 0) begin
                    want = '0;
                    flag_error("unexpected beat", want, seen);
                end else begin
                    want = owed_beats.pop_front();
                    if (want.event_res === llfd_pkg::EV_REJECT)
                        o_rejects++;
                    if (want.event_res === llfd_pkg::EV_FINISH)
                        o_finishes++;
                    if (want.event_res === llfd_pkg::EV_IDLE)
                        o_idle_ticks++;
                    if (seen.event_res !== want.event_res || seen.core !== want.core ||
                        seen.job_id !== want.job_id || seen.last !== want.last)
                        flag_error("mismatch", want, seen);
                end
            end

            // predict the results of an accepted input beat
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == llfd_pkg::CMD_ADD)
                    dispatch_add(i_job_length);
                else
                    dispatch_tick();
            end
        end
        o_pending <= owed_beats.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the dispatcher testbench: clock, reset, stimulus with idle and stall phases,
// and the verdict. Depends on llfd_pkg, least_loaded_fcfs_dispatcher and dispatch_monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [llfd_pkg::CFG_W-1:0]  i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_cmd;
    logic [llfd_pkg::LEN_W-1:0]  i_job_length;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [llfd_pkg::EV_W-1:0]   o_event_res;
    logic [llfd_pkg::CORE_W-1:0] o_core;
    logic [llfd_pkg::ID_W-1:0]   o_job_id;
    logic                        o_last;

    int errors;
    int pending;
    int beats;
    int rejects;
    int finishes;
    int idle_ticks;

    int items_sent;
    int cfg_writes;
    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int cycle_count;

    least_loaded_fcfs_dispatcher uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_job_length (i_job_length),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_res  (o_event_res),
        .o_core       (o_core),
        .o_job_id     (o_job_id),
        .o_last       (o_last)
    );

    dispatch_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_job_length (i_job_length),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_event_res  (o_event_res),
        .i_core       (o_core),
        .i_job_id     (o_job_id),
        .i_last       (o_last),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_rejects    (rejects),
        .o_finishes   (finishes),
        .o_idle_ticks (idle_ticks)
    );

    always #5 i_clk = ~i_clk;

    // bound the run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
            $display("testbench: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
    initial begin : receiver
        int hold_seen;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                for (int h = 0; h < HOLD_CYCLES; h++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offer one input beat, maybe after an idle gap, and hold it until accepted.
    task automatic send_item(input logic cmd, input logic [llfd_pkg::LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_job_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_cores(input logic [llfd_pkg::CFG_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly short jobs so queues drain, some zero-length, a few longer ones.
    function automatic logic [llfd_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        else if (r < 80)
            return llfd_pkg::LEN_W'($urandom_range(1, 4));
        else if (r < 95)
            return llfd_pkg::LEN_W'($urandom_range(5, 20));
        return llfd_pkg::LEN_W'($urandom_range(21, 40));
    endfunction

    task automatic random_burst(input int count, input int add_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < add_pct)
                send_item(llfd_pkg::CMD_ADD, pick_length());
            else
                send_item(llfd_pkg::CMD_TICK, $urandom);
        end
    endtask

    initial begin : stimulus
        logic [llfd_pkg::CFG_W-1:0] core_plan [8];
        core_plan = '{4'd8, 4'd3, 4'd0, 4'd2, 4'd15,
                      llfd_pkg::CFG_W'($urandom_range(0, 15)), 4'd1, 4'd9};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_cmd         = llfd_pkg::CMD_ADD;
        i_job_length  = '0;
        items_sent    = 0;
        cfg_writes    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single core: empty tick, zero-length job, then fill the queue until it rejects
        set_cores(4'd1);
        send_item(llfd_pkg::CMD_TICK, '0);
        send_item(llfd_pkg::CMD_ADD, '0);
        send_item(llfd_pkg::CMD_TICK, '1);
        repeat (16) send_item(llfd_pkg::CMD_ADD, 32'd1);
        send_item(llfd_pkg::CMD_ADD, 32'd2);
        send_item(llfd_pkg::CMD_TICK, '0);

        // random phases over core settings and idle/stall mixes
        for (int p = 0; p < 8; p++) begin
            set_cores(core_plan[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    send_idle_pct = 49;
                    stall_pct    <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 49;
                end
                default: begin
                    send_idle_pct = 20;
                    stall_pct    <= 20;
                end
            endcase
            // hold the output off long enough to back up the input
            if (p == 5)
                hold_req <= hold_req + 1;
            random_burst(38, (p % 2 == 1) ? 70 : 55);
        end

        // huge jobs last: they never finish, so they only pin queues at the end
        set_cores(4'd8);
        send_idle_pct = 20;
        stall_pct    <= 20;
        send_item(llfd_pkg::CMD_ADD, '1);
        send_item(llfd_pkg::CMD_ADD, {1'b1, 31'($urandom)});
        send_item(llfd_pkg::CMD_ADD, $urandom);
        send_item(llfd_pkg::CMD_ADD, $urandom | 32'h5555_0000);
        send_item(llfd_pkg::CMD_TICK, $urandom);
        send_item(llfd_pkg::CMD_TICK, '1);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d input beats over %0d core-count writes, one %0d-cycle output hold",
                 items_sent, cfg_writes, HOLD_CYCLES);
        $display("checked %0d result beats: %0d rejected adds, %0d finishes, %0d idle ticks",
                 beats, rejects, finishes, idle_ticks);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
